FILE: rtl/ntd_pkg.sv
package ntd_pkg;

    // fixed sizes of the stores
    localparam int NFA_N  = 16;
    localparam int SYM_N  = 8;
    localparam int DFA_N  = 64;
    localparam int NFA_W  = 4;
    localparam int SYM_W  = 3;
    localparam int DFA_W  = 6;
    localparam int CNT_W  = 7;
    localparam int MV_AW  = NFA_W + SYM_W;
    localparam int TBL_AW = DFA_W + SYM_W;

    // configuration register indexes
    localparam logic [1:0] CFG_NFA_COUNT = 2'd0;
    localparam logic [1:0] CFG_SYM_COUNT = 2'd1;
    localparam logic [1:0] CFG_START     = 2'd2;
    localparam int CFG_DW = 5;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REJECT   = 2'd1;
    localparam logic [1:0] ST_ACCEPT   = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef enum logic [2:0] {
        OP_LOAD_MOVE = 3'd0,
        OP_SET_FINAL = 3'd1,
        OP_LOAD_SYM  = 3'd2,
        OP_BUILD     = 3'd3,
        OP_BEGIN     = 3'd4,
        OP_STEP      = 3'd5,
        OP_END       = 3'd6,
        OP_READ      = 3'd7
    } t_op;

    typedef struct packed {
        t_op         opcode;
        logic [3:0]  nfa_state;
        logic [2:0]  symbol_index;
        logic [15:0] next_set;
        logic        final_mark;
        logic [7:0]  symbol_char;
        logic [5:0]  dfa_index;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  dfa_count;
        logic [5:0]  next_dfa_state;
        logic        next_defined;
        logic [15:0] subset_bits;
        logic        is_accepting;
        logic [5:0]  current_dfa_state;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OP1,
        S_OP2,
        S_OP3,
        S_OP4,
        S_B_INIT,
        S_B_CUR,
        S_B_CURL,
        S_B_SYM,
        S_B_MRD,
        S_B_MACC,
        S_B_CHK,
        S_B_LRD,
        S_B_LCMP,
        S_B_NEXT,
        S_B_KILL
    } t_state;

    typedef struct packed {
        logic req_load;
        logic op_exec;
        logic step_upd;
        logic out_rd;
        logic out_load;
        logic b_init;
        logic cur_rd;
        logic cur_ld;
        logic sym_start;
        logic mv_rd;
        logic mv_acc;
        logic chk;
        logic lk_rd;
        logic lk_cmp;
        logic b_next;
        logic b_kill;
    } t_cmd;

    typedef struct packed {
        logic k_last;
        logic nx_zero;
        logic lk_hit;
        logic lk_last;
        logic sym_last;
        logic row_end;
        logic kill;
    } t_sts;

endpackage

FILE: rtl/ntd_ctrl.sv
module ntd_ctrl
    import ntd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_op  i_opcode,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic busy
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.req_load = 1'b1;
                    n_state = (i_opcode == OP_BUILD) ? S_B_INIT : S_OP1;
                end
            end
            S_OP1: begin
                o_cmd.op_exec = 1'b1;
                n_state = S_OP2;
            end
            S_OP2: begin
                o_cmd.step_upd = 1'b1;
                n_state = S_OP3;
            end
            S_OP3: begin
                o_cmd.out_rd = 1'b1;
                n_state = S_OP4;
            end
            S_OP4: begin
                o_cmd.out_load = 1'b1;
                n_state = S_IDLE;
            end
            S_B_INIT: begin
                o_cmd.b_init = 1'b1;
                n_state = S_B_CUR;
            end
            S_B_CUR: begin
                o_cmd.cur_rd = 1'b1;
                n_state = S_B_CURL;
            end
            S_B_CURL: begin
                o_cmd.cur_ld = 1'b1;
                n_state = S_B_SYM;
            end
            S_B_SYM: begin
                o_cmd.sym_start = 1'b1;
                n_state = S_B_MRD;
            end
            S_B_MRD: begin
                o_cmd.mv_rd = 1'b1;
                n_state = S_B_MACC;
            end
            S_B_MACC: begin
                o_cmd.mv_acc = 1'b1;
                n_state = i_sts.k_last ? S_B_CHK : S_B_MRD;
            end
            S_B_CHK: begin
                o_cmd.chk = 1'b1;
                n_state = i_sts.nx_zero ? S_B_NEXT : S_B_LRD;
            end
            S_B_LRD: begin
                o_cmd.lk_rd = 1'b1;
                n_state = S_B_LCMP;
            end
            S_B_LCMP: begin
                o_cmd.lk_cmp = 1'b1;
                n_state = (i_sts.lk_hit || i_sts.lk_last) ? S_B_NEXT : S_B_LRD;
            end
            S_B_NEXT: begin
                o_cmd.b_next = 1'b1;
                if (i_sts.sym_last && i_sts.row_end) begin
                    n_state = S_OP4;
                end else if (i_sts.kill) begin
                    n_state = S_B_KILL;
                end else if (i_sts.sym_last) begin
                    n_state = S_B_CUR;
                end else begin
                    n_state = S_B_SYM;
                end
            end
            S_B_KILL: begin
                o_cmd.b_kill = 1'b1;
                n_state = S_B_NEXT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/ntd_dpath.sv
module ntd_dpath
    import ntd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_req              i_req,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    output logic              o_strobe,
    output t_rsp              o_rsp
);

    t_req               r_req;
    logic [4:0]         r_ns_cfg;
    logic [3:0]         r_na_cfg;
    logic [3:0]         r_start_cfg;
    logic [NFA_N-1:0]   r_final;
    logic [NFA_N-1:0]   r_mv_mem [2**MV_AW];
    logic [2**MV_AW-1:0] r_mv_valid;
    logic [NFA_N-1:0]   r_mv_q;
    logic               r_mv_v;
    logic [7:0]         r_chars [SYM_N];
    logic [NFA_N:0]     r_sub_mem [DFA_N];
    logic [NFA_N:0]     r_sub_q;
    logic [DFA_W:0]     r_tbl_mem [2**TBL_AW];
    logic [DFA_W:0]     r_tbl_q;
    logic [CNT_W-1:0]   r_built;
    logic [DFA_W-1:0]   r_wh;
    logic [SYM_W-1:0]   r_sym;
    logic [NFA_W-1:0]   r_k;
    logic [DFA_W-1:0]   r_lk;
    logic [NFA_N-1:0]   r_cur;
    logic [NFA_N-1:0]   r_nx;
    logic               r_kill;
    logic [DFA_W-1:0]   r_run;
    logic               r_dead;
    logic               r_step_live;
    logic               r_found;
    logic               r_step_ok;
    logic               r_strobe;
    t_rsp               r_rsp;

    logic [4:0]         ns;
    logic [3:0]         na;
    logic [NFA_W-1:0]   start_eff;
    logic [NFA_N-1:0]   used;
    logic [NFA_N-1:0]   nx_m;
    logic [NFA_N-1:0]   start_bit;
    logic [SYM_W-1:0]   fidx;
    logic               found;
    logic               live;
    logic               lk_hit;
    logic               full;
    logic               tbl_we;
    logic [TBL_AW-1:0]  tbl_wa;
    logic [DFA_W:0]     tbl_wd;
    logic               tbl_re;
    logic [TBL_AW-1:0]  tbl_ra;
    logic               sub_we;
    logic [DFA_W-1:0]   sub_wa;
    logic [NFA_N:0]     sub_wd;
    logic               sub_re;
    logic [DFA_W-1:0]   sub_ra;
    logic [NFA_N-1:0]   mv_data;
    t_rsp               n_rsp;

    // effective counts and masks
    always_comb begin
        if (r_ns_cfg == 5'd0) begin
            ns = 5'd1;
        end else if (r_ns_cfg > 5'(NFA_N)) begin
            ns = 5'(NFA_N);
        end else begin
            ns = r_ns_cfg;
        end
        if (r_na_cfg == 4'd0) begin
            na = 4'd1;
        end else if (r_na_cfg > 4'(SYM_N)) begin
            na = 4'(SYM_N);
        end else begin
            na = r_na_cfg;
        end
        start_eff = ({1'b0, r_start_cfg} < ns) ? r_start_cfg : '0;
        for (int b = 0; b < NFA_N; b++) begin
            used[b] = 5'(b) < ns;
        end
        start_bit = '0;
        start_bit[start_eff] = 1'b1;
    end

    assign nx_m    = r_nx & used;
    assign mv_data = r_mv_v ? r_mv_q : '0;
    assign lk_hit  = r_sub_q[NFA_N-1:0] == nx_m;
    assign full    = r_built == CNT_W'(DFA_N);
    assign live    = !r_dead && ({1'b0, r_run} < r_built);

    // character search, first match among symbols in use
    always_comb begin
        found = 1'b0;
        fidx  = '0;
        for (int j = SYM_N - 1; j >= 0; j--) begin
            if ((4'(j) < na) && (r_chars[j] == r_req.symbol_char)) begin
                found = 1'b1;
                fidx  = SYM_W'(j);
            end
        end
    end

    // status to the controller
    always_comb begin
        o_sts.k_last   = r_k == NFA_W'(NFA_N - 1);
        o_sts.nx_zero  = nx_m == '0;
        o_sts.lk_hit   = lk_hit;
        o_sts.lk_last  = ({1'b0, r_lk} + CNT_W'(1)) == r_built;
        o_sts.sym_last = ({1'b0, r_sym} + 4'd1) == na;
        o_sts.row_end  = ({1'b0, r_wh} + CNT_W'(1)) == r_built;
        o_sts.kill     = r_kill;
    end

    // transition table port control
    always_comb begin
        tbl_we = 1'b0;
        tbl_wa = {r_wh, r_sym};
        tbl_wd = '0;
        if (i_cmd.chk && (nx_m == '0)) begin
            tbl_we = 1'b1;
        end else if (i_cmd.lk_cmp) begin
            if (lk_hit) begin
                tbl_we = 1'b1;
                tbl_wd = {1'b1, r_lk};
            end else if (o_sts.lk_last) begin
                tbl_we = 1'b1;
                tbl_wd = full ? '0 : {1'b1, r_built[DFA_W-1:0]};
            end
        end else if (i_cmd.b_kill) begin
            tbl_we = 1'b1;
        end
        tbl_re = i_cmd.op_exec;
        tbl_ra = (r_req.opcode == OP_STEP) ? {r_run, fidx}
                                           : {r_req.dfa_index, r_req.symbol_index};
    end

    // subset store port control
    always_comb begin
        sub_we = 1'b0;
        sub_wa = r_built[DFA_W-1:0];
        sub_wd = {(nx_m & r_final) != '0, nx_m};
        if (i_cmd.b_init) begin
            sub_we = 1'b1;
            sub_wa = '0;
            sub_wd = {(start_bit & r_final) != '0, start_bit};
        end else if (i_cmd.lk_cmp && !lk_hit && o_sts.lk_last && !full) begin
            sub_we = 1'b1;
        end
        sub_re = i_cmd.cur_rd || i_cmd.lk_rd || i_cmd.out_rd;
        if (i_cmd.cur_rd) begin
            sub_ra = r_wh;
        end else if (i_cmd.lk_rd) begin
            sub_ra = r_lk;
        end else if (r_req.opcode == OP_READ) begin
            sub_ra = r_req.dfa_index;
        end else begin
            sub_ra = r_run;
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl_mem[tbl_wa] <= tbl_wd;
        end
        if (tbl_re) begin
            r_tbl_q <= r_tbl_mem[tbl_ra];
        end
        if (sub_we) begin
            r_sub_mem[sub_wa] <= sub_wd;
        end
        if (sub_re) begin
            r_sub_q <= r_sub_mem[sub_ra];
        end
        if (i_cmd.op_exec && (r_req.opcode == OP_LOAD_MOVE)) begin
            r_mv_mem[{r_req.nfa_state, r_req.symbol_index}] <= r_req.next_set;
        end
        if (i_cmd.mv_rd) begin
            r_mv_q <= r_mv_mem[{r_k, r_sym}];
        end
    end

    // move store valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv_valid <= '0;
            r_mv_v     <= 1'b0;
        end else begin
            if (i_cmd.op_exec && (r_req.opcode == OP_LOAD_MOVE)) begin
                r_mv_valid[{r_req.nfa_state, r_req.symbol_index}] <= 1'b1;
            end
            if (i_cmd.mv_rd) begin
                r_mv_v <= r_mv_valid[{r_k, r_sym}];
            end
        end
    end

    // request latch, symbol characters and build working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_req <= i_req;
        end
        if (i_cmd.op_exec && (r_req.opcode == OP_LOAD_SYM)) begin
            r_chars[r_req.symbol_index] <= r_req.symbol_char;
        end
        if (i_cmd.op_exec) begin
            r_step_live <= live;
            r_found     <= found;
        end
        if (i_cmd.cur_ld) begin
            r_cur <= r_sub_q[NFA_N-1:0];
        end
        if (i_cmd.sym_start) begin
            r_k  <= '0;
            r_nx <= '0;
        end
        if (i_cmd.mv_acc) begin
            r_nx <= r_nx | (r_cur[r_k] ? mv_data : '0);
            r_k  <= r_k + NFA_W'(1);
        end
        if (i_cmd.chk) begin
            r_lk <= '0;
        end
        if (i_cmd.lk_cmp) begin
            r_lk <= r_lk + DFA_W'(1);
        end
    end

    // configuration, final mask, build counters and run registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ns_cfg    <= 5'd1;
            r_na_cfg    <= 4'd1;
            r_start_cfg <= '0;
            r_final     <= '0;
            r_built     <= '0;
            r_wh        <= '0;
            r_sym       <= '0;
            r_kill      <= 1'b0;
            r_run       <= '0;
            r_dead      <= 1'b0;
            r_step_ok   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NFA_COUNT: r_ns_cfg    <= i_cfg_data;
                    CFG_SYM_COUNT: r_na_cfg    <= i_cfg_data[3:0];
                    CFG_START:     r_start_cfg <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_cmd.op_exec && (r_req.opcode == OP_SET_FINAL)) begin
                r_final[r_req.nfa_state] <= r_req.final_mark;
            end
            if (i_cmd.op_exec && (r_req.opcode == OP_BEGIN)) begin
                r_run  <= '0;
                r_dead <= r_built == '0;
            end
            // step outcome once the table entry is back
            if (i_cmd.step_upd && (r_req.opcode == OP_STEP)) begin
                if (r_step_live && r_found && r_tbl_q[DFA_W]) begin
                    r_run     <= r_tbl_q[DFA_W-1:0];
                    r_step_ok <= 1'b1;
                end else begin
                    r_dead    <= 1'b1;
                    r_step_ok <= 1'b0;
                end
            end
            if (i_cmd.b_init) begin
                r_built <= CNT_W'(1);
                r_wh    <= '0;
                r_sym   <= '0;
                r_kill  <= 1'b0;
            end
            // new subset appended, or store full
            if (i_cmd.lk_cmp && !lk_hit && o_sts.lk_last) begin
                if (full) begin
                    r_kill <= 1'b1;
                end else begin
                    r_built <= r_built + CNT_W'(1);
                end
            end
            if (i_cmd.b_next) begin
                if (o_sts.sym_last) begin
                    r_sym <= '0;
                    r_wh  <= r_wh + DFA_W'(1);
                end else begin
                    r_sym <= r_sym + SYM_W'(1);
                end
            end
        end
    end

    // result assembly
    always_comb begin
        n_rsp = '0;
        n_rsp.status = ST_OK;
        n_rsp.dfa_count = r_built;
        n_rsp.current_dfa_state = r_run;
        case (r_req.opcode)
            OP_BUILD: begin
                n_rsp.status = r_kill ? ST_OVERFLOW : ST_OK;
            end
            OP_BEGIN, OP_STEP, OP_END: begin
                if (live) begin
                    n_rsp.subset_bits  = r_sub_q[NFA_N-1:0];
                    n_rsp.is_accepting = r_sub_q[NFA_N];
                end
                if (r_req.opcode == OP_STEP) begin
                    n_rsp.status         = r_step_ok ? ST_OK : ST_REJECT;
                    n_rsp.next_defined   = r_step_ok;
                    n_rsp.next_dfa_state = r_step_ok ? r_run : '0;
                end else if (r_req.opcode == OP_END) begin
                    n_rsp.status = (live && r_sub_q[NFA_N]) ? ST_ACCEPT : ST_REJECT;
                end
            end
            OP_READ: begin
                if ({1'b0, r_req.dfa_index} >= r_built) begin
                    n_rsp.status = ST_REJECT;
                end else begin
                    n_rsp.subset_bits  = r_sub_q[NFA_N-1:0];
                    n_rsp.is_accepting = r_sub_q[NFA_N];
                    if (({1'b0, r_req.symbol_index} < na) && r_tbl_q[DFA_W]) begin
                        n_rsp.next_defined   = 1'b1;
                        n_rsp.next_dfa_state = r_tbl_q[DFA_W-1:0];
                    end
                end
            end
            default: begin
                n_rsp.status = ST_OK;
            end
        endcase
    end

    // result register and strobe
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_rsp <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.out_load;
        end
    end

    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

FILE: rtl/nfa_to_dfa_subset_builder.sv
// loads, set final, symbol loads, begin, step, end and read entry: request latch, then
// execute, step update, output read and result load; no new request is taken while busy
// build: for each (dfa state, symbol) pair, a serial union over the move store and a
// serial scan of the subset store
// synchronous active-low reset clears control, configuration, counters, run registers
// and move store valid bits; the result shows for one cycle on o_strobe, no stall
module nfa_to_dfa_subset_builder
    import ntd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  t_req              i_req,
    output logic              busy,
    output logic              o_strobe,
    output t_rsp              o_rsp,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // sequencer
    ntd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_req.opcode),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    // stores, counters and result register
    ntd_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_strobe   (o_strobe),
        .o_rsp      (o_rsp)
    );

endmodule
